// ===== rtl/core/ush_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ush_pkg;

  // Table index width; the modulus is clamped to 2 .. 2**INDEX_BITS.
  localparam int INDEX_BITS = 15;

  localparam int HASH_W = 15;           // running hash, coefficient, result
  localparam int CH_W   = 8;            // key byte
  localparam int MOD_W  = HASH_W + 1;   // modulus incl. 2**15
  localparam int DVD_W  = 2 * HASH_W;   // a*h + c stays below 2**30

  // Remainder unit retires two dividend bits per cycle.
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int QUEUE_DEPTH = 2;       // power of two, pointers wrap
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [HASH_W-1:0] START_COEFF = HASH_W'(31415);
  localparam logic [HASH_W-1:0] COEFF_STEP  = HASH_W'(27183);
  localparam logic [MOD_W-1:0]  TABLE_SIZE_RESET = MOD_W'(101);
  localparam logic [MOD_W-1:0]  MOD_MIN   = MOD_W'(2);
  localparam logic [MOD_W-1:0]  MOD_LIMIT = MOD_W'(1 << INDEX_BITS);

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_END  = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [CH_W-1:0]   ch;
  } q_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_DONE = 2'd2
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/universal_string_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Path: an end-of-key transfer goes through the queue, a load into the
//   remainder units, remainder steps at 2 bits each on a 30-bit dividend,
//   and a write-back before out_valid.
// The back end takes one item at a time, on two remainder units in parallel.
// Reset (rst_n low, synchronous): queue and output empty, hash 0,
//   coefficient 31415, table_size 101.

module universal_string_hash (
  input  wire                             clk,
  input  wire                             rst_n,
  // input channel: one key byte or end-of-key marker per transfer
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             in_op,
  input  wire  [ush_pkg::CH_W-1:0]        in_ch,
  // result channel: one hash per finished key
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [ush_pkg::HASH_W-1:0]      out_hash,
  // table_size register
  input  wire                             cfg_wr_en,
  input  wire  [ush_pkg::MOD_W-1:0]       cfg_wr_data
);

  logic [ush_pkg::MOD_W-1:0]  table_size_r;
  logic [ush_pkg::MOD_W-1:0]  mod_m;
  logic                       q_valid, q_ready;
  ush_pkg::q_entry_t          q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= ush_pkg::TABLE_SIZE_RESET;
    end else if (cfg_wr_en) begin
      table_size_r <= cfg_wr_data;
    end
  end

  // Effective modulus: 0 and 1 act as 2, anything past 2**INDEX_BITS is
  // clamped. User must change config only while idle; not enforced here.
  always_comb begin
    priority if (table_size_r < ush_pkg::MOD_MIN) begin
      mod_m = ush_pkg::MOD_MIN;
    end else if (table_size_r > ush_pkg::MOD_LIMIT) begin
      mod_m = ush_pkg::MOD_LIMIT;
    end else begin
      mod_m = table_size_r;
    end
  end

  // Front end: takes transfers and queues them, so input keeps flowing
  // while the back end grinds through a remainder, until the queue fills.
  ush_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_ch     (in_ch),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_entry_o (q_entry)
  );

  // Back end: h = (a*h + c) mod M, a = (a*27183) mod (M-1); on end of key
  // emits h mod M into an output register and restarts the key.
  ush_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mod_m_i   (mod_m),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_entry_i (q_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hash  (out_hash)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ush_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Accepts input transfers, tags them as key byte or end of key, and
// buffers them in a small FIFO for the back end.
module ush_front (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             in_op,
  input  wire  [ush_pkg::CH_W-1:0]        in_ch,
  output logic                            q_valid_o,
  input  wire                             q_ready_i,
  output ush_pkg::q_entry_t               q_entry_o
);

  ush_pkg::q_entry_t                  mem_r [ush_pkg::QUEUE_DEPTH];
  logic [ush_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [ush_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [ush_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;
  ush_pkg::q_entry_t                  entry_in;
  logic                               push, pop;

  assign in_ready  = (cnt_r != ush_pkg::QCNT_W'(ush_pkg::QUEUE_DEPTH));
  assign q_valid_o = (cnt_r != '0);
  assign q_entry_o = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = q_valid_o && q_ready_i;

  always_comb begin
    entry_in.kind = in_op ? ush_pkg::KIND_END : ush_pkg::KIND_CHAR;
    entry_in.ch   = in_ch;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry_in;
    end
  end

  // fill level tracks pointer distance
  a_cnt_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == ush_pkg::QCNT_W'(ush_pkg::QUEUE_DEPTH))
      |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue count disagrees with pointers");

endmodule

`default_nettype wire

// ===== rtl/core/ush_mod_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder unit, two dividend bits per step, MSB first.
// Divisor is latched at start; remainder is final after DIV_STEPS steps.
module ush_mod_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start_i,
  input  wire                             step_i,
  input  wire  [ush_pkg::DVD_W-1:0]       dividend_i,
  input  wire  [ush_pkg::MOD_W-1:0]       divisor_i,
  output logic [ush_pkg::HASH_W-1:0]      rem_o
);

  logic [ush_pkg::DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [ush_pkg::MOD_W-1:0]   div_r, div_nxt;
  logic [ush_pkg::HASH_W-1:0]  rem_r, rem_nxt;
  logic [ush_pkg::MOD_W-1:0]   t1, t2;
  logic [ush_pkg::HASH_W-1:0]  r1, r2;

  always_comb begin
    t1 = {rem_r, dvd_r[ush_pkg::DVD_W-1]};
    r1 = (t1 >= div_r) ? ush_pkg::HASH_W'(t1 - div_r) : t1[ush_pkg::HASH_W-1:0];
    t2 = {r1, dvd_r[ush_pkg::DVD_W-2]};
    r2 = (t2 >= div_r) ? ush_pkg::HASH_W'(t2 - div_r) : t2[ush_pkg::HASH_W-1:0];
  end

  always_comb begin
    dvd_nxt = dvd_r;
    div_nxt = div_r;
    rem_nxt = rem_r;
    if (start_i) begin
      dvd_nxt = dividend_i;
      div_nxt = divisor_i;
      rem_nxt = '0;
    end else if (step_i) begin
      dvd_nxt = {dvd_r[ush_pkg::DVD_W-3:0], 2'b00};
      rem_nxt = r2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= ush_pkg::MOD_W'(1);
      rem_r <= '0;
    end else begin
      div_r <= div_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
  end

  assign rem_o = rem_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (div_r != '0) |-> (ush_pkg::MOD_W'(rem_r) < div_r))
    else $error("partial remainder not below divisor");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |=> (rem_r == '0))
    else $error("remainder not cleared at start");

endmodule

`default_nettype wire

// ===== rtl/core/ush_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Executes queued items: a multiply loaded into the units at start, DIV_STEPS
// remainder steps on two parallel units (hash mod M, coefficient mod M-1),
// then write-back or result load.
module ush_back (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire  [ush_pkg::MOD_W-1:0]       mod_m_i,
  input  wire                             q_valid_i,
  output logic                            q_ready_o,
  input  ush_pkg::q_entry_t               q_entry_i,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [ush_pkg::HASH_W-1:0]      out_hash
);

  ush_pkg::state_t              state_r, state_nxt;
  ush_pkg::item_kind_t          kind_r;
  logic [ush_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [ush_pkg::HASH_W-1:0]   hash_r, hash_nxt;
  logic [ush_pkg::HASH_W-1:0]   coef_r, coef_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [ush_pkg::HASH_W-1:0]   out_hash_r;

  logic                         div_start, div_step, upd_char, out_load;
  logic                         out_free, last_step;
  logic [ush_pkg::DVD_W-1:0]    prod_h, prod_a;
  logic [ush_pkg::MOD_W-1:0]    mod_m1;
  logic [ush_pkg::HASH_W-1:0]   rem_h, rem_a;

  assign out_free  = !out_valid_r || out_ready;
  assign last_step = (cnt_r == ush_pkg::STEP_W'(ush_pkg::DIV_STEPS - 1));
  assign mod_m1    = mod_m_i - 1'b1;

  // end of key just re-reduces the running hash against the current M
  always_comb begin
    if (q_entry_i.kind == ush_pkg::KIND_END) begin
      prod_h = ush_pkg::DVD_W'(hash_r);
    end else begin
      prod_h = ush_pkg::DVD_W'(coef_r) * ush_pkg::DVD_W'(hash_r)
             + ush_pkg::DVD_W'(q_entry_i.ch);
    end
    prod_a = ush_pkg::DVD_W'(coef_r) * ush_pkg::DVD_W'(ush_pkg::COEFF_STEP);
  end

  ush_mod_unit u_mod_h (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .step_i     (div_step),
    .dividend_i (prod_h),
    .divisor_i  (mod_m_i),
    .rem_o      (rem_h)
  );

  ush_mod_unit u_mod_a (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .step_i     (div_step),
    .dividend_i (prod_a),
    .divisor_i  (mod_m1),
    .rem_o      (rem_a)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ush_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          state_nxt = ush_pkg::ST_DIV;
        end
      end
      ush_pkg::ST_DIV: begin
        if (last_step) begin
          state_nxt = ush_pkg::ST_DONE;
        end
      end
      ush_pkg::ST_DONE: begin
        if (kind_r == ush_pkg::KIND_CHAR || out_free) begin
          state_nxt = ush_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ush_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    q_ready_o = 1'b0;
    div_start = 1'b0;
    div_step  = 1'b0;
    upd_char  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ush_pkg::ST_IDLE: begin
        q_ready_o = 1'b1;
        div_start = q_valid_i;
      end
      ush_pkg::ST_DIV: begin
        div_step = 1'b1;
      end
      ush_pkg::ST_DONE: begin
        if (kind_r == ush_pkg::KIND_CHAR) begin
          upd_char = 1'b1;
        end else begin
          out_load = out_free;
        end
      end
      default: begin
        q_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = div_start ? '0 : (div_step ? cnt_r + 1'b1 : cnt_r);
    hash_nxt = hash_r;
    coef_nxt = coef_r;
    if (upd_char) begin
      hash_nxt = rem_h;
      coef_nxt = rem_a;
    end else if (out_load) begin
      hash_nxt = '0;
      coef_nxt = ush_pkg::START_COEFF;
    end
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ush_pkg::ST_IDLE;
      cnt_r       <= '0;
      hash_r      <= '0;
      coef_r      <= ush_pkg::START_COEFF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hash_r      <= hash_nxt;
      coef_r      <= coef_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      kind_r <= q_entry_i.kind;
    end
    if (out_load) begin
      out_hash_r <= rem_h;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ush_pkg::ST_DIV) |-> (cnt_r < ush_pkg::STEP_W'(ush_pkg::DIV_STEPS)))
    else $error("remainder step count out of range");

  a_key_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && hash_r == '0 && coef_r == ush_pkg::START_COEFF))
    else $error("state not restored after end of key");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ush_pkg::*;

  // Hash recurrence constants and register reset value
  localparam int unsigned KEY_COEFF_START  = 31415;
  localparam int unsigned KEY_COEFF_MULT   = 27183;
  localparam int unsigned TABLE_SIZE_AT_RST = 101;
  localparam int unsigned TABLE_MOD_MAX     = 1 << INDEX_BITS;

  // Chars produce no result, so "nothing pending" does not mean the core is
  // done: up to queue depth + 1 chars may still be in work.
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 800;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_op = 1'b0;
  logic [CH_W-1:0]      in_ch = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [HASH_W-1:0]    out_hash;
  logic                 cfg_wr_en = 1'b0;
  logic [MOD_W-1:0]     cfg_wr_data = '0;

  // Shadow state of the hash core
  logic [MOD_W-1:0]     mdl_table_size = MOD_W'(TABLE_SIZE_AT_RST);
  logic [HASH_W-1:0]    mdl_hash = '0;
  logic [HASH_W-1:0]    mdl_coeff = HASH_W'(KEY_COEFF_START);

  logic [HASH_W-1:0]    pending_hashes[$];
  int                   errors = 0;

  // Sender burst bookkeeping
  int                   burst_left = 0;

  // Receiver stall pattern
  int                   rdy_seg_left = 0;
  int                   rdy_mode = 0;
  int                   rdy_hold = 0;

  universal_string_hash u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_ch       (in_ch),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_hash    (out_hash),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the shadow hash by one accepted item. A char folds the byte in
  // and steps the coefficient; an end-of-key pushes the finished index.
  task automatic advance_key_hash(input item_kind_t kind, input logic [CH_W-1:0] c);
    int unsigned m;
    int unsigned a;
    int unsigned h;
    m = mdl_table_size;
    if (m < 2) m = 2;                         // too-small modulus runs as 2
    if (m > TABLE_MOD_MAX) m = TABLE_MOD_MAX; // too-large modulus clamps
    a = mdl_coeff;
    h = mdl_hash;
    if (kind == KIND_CHAR) begin
      mdl_hash  = HASH_W'((a * h + c) % m);
      // with M == 2 this goes to 0 since everything mod 1 is 0
      mdl_coeff = HASH_W'((a * KEY_COEFF_MULT) % (m - 1));
    end else begin
      // extra reduction covers a modulus changed in mid-key
      pending_hashes.push_back(HASH_W'(h % m));
      mdl_hash  = '0;
      mdl_coeff = HASH_W'(KEY_COEFF_START);
    end
  endtask

  // One input transfer; bursts of random length with random gaps between.
  task automatic send_item(input item_kind_t kind, input logic [CH_W-1:0] c);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        // long stretch with no idling on the input side
        gap = 0;
        burst_left = $urandom_range(50, 200);
      end else begin
        gap = $urandom_range(1, 40);
        burst_left = $urandom_range(1, 20);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op    <= kind;
    in_ch    <= c;
    do @(posedge clk); while (!in_ready);
    advance_key_hash(kind, c);
  endtask

  // Stop sending, let every result arrive, then let in-flight chars retire.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [MOD_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    mdl_table_size = value;
    cfg_wr_en <= 1'b0;
  endtask

  // Empty key, extreme bytes, end item with nonzero ignored byte; reset M.
  task automatic test_reset_state();
    send_item(KIND_END, 8'h00);
    send_item(KIND_CHAR, 8'hFF);
    send_item(KIND_CHAR, 8'h00);
    send_item(KIND_END, 8'hFF);
  endtask

  // Modulus of zero and one, at the limit and above the limit.
  task automatic test_modulus_clamps();
    logic [MOD_W-1:0] sizes[4];
    sizes = '{MOD_W'(0), MOD_W'(1), MOD_W'(TABLE_MOD_MAX), {MOD_W{1'b1}}};
    foreach (sizes[i]) begin
      write_table_size(sizes[i]);
      send_item(KIND_CHAR, 8'hFF);
      send_item(KIND_CHAR, 8'hFF);
      send_item(KIND_END, 8'h5A);
    end
  endtask

  // Table resized between chars of the same key.
  task automatic test_midkey_resize();
    write_table_size(MOD_W'(1000));
    send_item(KIND_CHAR, 8'h41);
    send_item(KIND_CHAR, 8'h42);
    write_table_size(MOD_W'(7));
    send_item(KIND_CHAR, 8'h43);
    send_item(KIND_END, 8'h00);
  endtask

  task automatic test_random_keys();
    int sent;
    int nkeys;
    int klen;
    logic [MOD_W-1:0] ts;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: ts = MOD_W'(2);
        1: ts = MOD_W'(TABLE_MOD_MAX);
        2: ts = MOD_W'($urandom_range(0, 1));
        3: ts = MOD_W'($urandom_range(TABLE_MOD_MAX + 1, 65535));
        4: ts = MOD_W'($urandom_range(3, 40));
        default: ts = MOD_W'($urandom_range(2, TABLE_MOD_MAX));
      endcase
      write_table_size(ts);
      nkeys = $urandom_range(5, 15);
      repeat (nkeys) begin
        // mostly short keys, now and then a long one; length 0 = empty key
        klen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        repeat (klen) send_item(KIND_CHAR, CH_W'($urandom_range(0, 255)));
        if (klen > 0 && $urandom_range(0, 15) == 0)
          write_table_size(MOD_W'($urandom_range(0, 65535)));
        send_item(KIND_END, CH_W'($urandom_range(0, 255)));
        sent += klen + 1;
      end
    end
  endtask

  // Receiver: segments of always-ready, coin-flip, and long stalls.
  always @(posedge clk) begin
    if (rdy_seg_left == 0) begin
      rdy_seg_left <= $urandom_range(50, 300);
      rdy_mode     <= $urandom_range(0, 2);
    end else begin
      rdy_seg_left <= rdy_seg_left - 1;
    end
    case (rdy_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (rdy_hold == 0) begin
          out_ready <= !out_ready;
          rdy_hold  <= out_ready ? $urandom_range(1, 25) : $urandom_range(0, 3);
        end else begin
          rdy_hold <= rdy_hold - 1;
        end
      end
    endcase
  end

  // Each result transfer is checked against the oldest expected index.
  always @(posedge clk) begin
    logic [HASH_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t unexpected hash: expected none, got %0d", $time, out_hash);
        errors++;
      end else begin
        want = pending_hashes.pop_front();
        if (out_hash !== want) begin
          $display("%0t hash mismatch: expected %0d, got %0d", $time, want, out_hash);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_modulus_clamps();
    test_midkey_resize();
    test_random_keys();
    wait_idle();
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ush_pkg.sv
rtl/core/ush_front.sv
rtl/core/ush_mod_unit.sv
rtl/core/ush_back.sv
rtl/core/universal_string_hash.sv
bench/testbench.sv
